@@ src/xmr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmr_pkg
// Types, codes and helpers shared by the XMODEM receiver modules.
// ----------------------------------------------------------------------------
package xmr_pkg;

	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_C   = 8'h43;

	localparam int MAX_RES = 5;
	localparam int RES_W   = 3;   // holds 0..MAX_RES

	localparam logic [23:0] DEF_CAPACITY    = 24'hFFFFFF;
	localparam logic [15:0] DEF_HEADER_WAIT = 16'd2000;
	localparam logic [15:0] DEF_SHORT_WAIT  = 16'd1000;
	localparam logic [7:0]  DEF_SYNC_RETRY  = 8'd32;
	localparam logic [7:0]  DEF_MAX_RETRANS = 8'd25;

	typedef enum logic [2:0] {
		REG_CAPACITY    = 3'd0,
		REG_HEADER_WAIT = 3'd1,
		REG_SHORT_WAIT  = 3'd2,
		REG_SYNC_RETRY  = 3'd3,
		REG_MAX_RETRANS = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_BYTE  = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_CANWAIT = 2'd2,
		PH_BODY    = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		TRY_NONE = 2'd0,
		TRY_C    = 2'd1,
		TRY_NAK  = 2'd2
	} try_t;

	typedef enum logic [2:0] {
		K_TX      = 3'd0,
		K_PAY     = 3'd1,
		K_COMMIT  = 3'd2,
		K_DISCARD = 3'd3,
		K_DONE    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_COMPLETE = 2'd0,
		ST_CANCEL   = 2'd1,
		ST_SYNC     = 2'd2,
		ST_RETRANS  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  out_kind;
		logic [7:0]  out_byte;
		logic [10:0] commit_count;
		logic [1:0]  status;
		logic [23:0] total_length;
		logic        last;
	} out_item_t;

	// one result slot without total_length/last (filled at drain time)
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data;
		logic [10:0] count;
		logic [1:0]  status;
	} slot_t;

	typedef struct packed {
		logic [23:0] capacity;
		logic [15:0] header_wait;
		logic [15:0] short_wait;
		logic [7:0]  sync_retries;
		logic [7:0]  max_retrans;
	} cfg_t;

	// batch of results caused by one item
	typedef struct packed {
		slot_t [MAX_RES-1:0] slot;
		logic [RES_W-1:0]    count;
		logic [23:0]         total;
	} batch_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
	                                           input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		return c;
	endfunction

endpackage
`default_nettype wire

@@ src/xmr_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmr_core
// Protocol state and per-item decision logic; yields a batch of results.
// ----------------------------------------------------------------------------
module xmr_core import xmr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_item_t item,
	input  wire cfg_t     cfg,
	output batch_t        batch
);

	phase_t      phase_q, phase_d;
	logic [7:0]  attempt_q, attempt_d;
	try_t        try_q, try_d;
	logic        crc_mode_q, crc_mode_d;
	logic [7:0]  exp_blk_q, exp_blk_d;
	logic [7:0]  retrans_q, retrans_d;
	logic [23:0] deliv_q, deliv_d;
	logic [15:0] wait_q, wait_d;
	logic [10:0] idx_q, idx_d;
	logic        large_q, large_d;
	logic [7:0]  blk_q, blk_d;
	logic [7:0]  inv_q, inv_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  crch_q, crch_d;

	slot_t [MAX_RES-1:0] sl;
	logic [RES_W-1:0]    n;

	logic [15:0] wait_inc, hdr_lim, sht_lim;
	logic [7:0]  sync_lim, att_inc;
	logic [10:0] size;
	logic [23:0] room;
	logic [10:0] cnt;
	logic        blk_ok, is_new, is_dup, chk_ok;
	logic [7:0]  b;

	always_comb begin
		wait_inc = wait_q + 16'd1;
		hdr_lim  = (cfg.header_wait == 16'd0) ? 16'd1 : cfg.header_wait;
		sht_lim  = (cfg.short_wait == 16'd0) ? 16'd1 : cfg.short_wait;
		sync_lim = (cfg.sync_retries == 8'd0) ? 8'd1 : cfg.sync_retries;
		att_inc  = attempt_q + 8'd1;
		size     = large_q ? 11'd1024 : 11'd128;
		room     = (cfg.capacity > deliv_q) ? (cfg.capacity - deliv_q) : 24'd0;
		cnt      = (room > {13'd0, size}) ? size : room[10:0];
		blk_ok   = blk_q == ~inv_q;
		is_new   = blk_q == exp_blk_q;
		is_dup   = blk_q == (exp_blk_q - 8'd1);
		b        = item.rx_byte;
		chk_ok   = crc_mode_q ? ({crch_q, b} == crc_q) : (b == sum_q);
	end

	// append one result
	function automatic void put(inout slot_t [MAX_RES-1:0] s, inout logic [RES_W-1:0] k,
	                            input kind_t kd, input logic [7:0] d,
	                            input logic [10:0] c, input status_t st);
		s[k[2:0]] = '{kind: kd, data: d, count: c, status: st};
		k = k + RES_W'(1);
	endfunction

	always_comb begin
		phase_d = phase_q; attempt_d = attempt_q; try_d = try_q;
		crc_mode_d = crc_mode_q; exp_blk_d = exp_blk_q; retrans_d = retrans_q;
		deliv_d = deliv_q; wait_d = wait_q; idx_d = idx_q; large_d = large_q;
		blk_d = blk_q; inv_d = inv_q; crc_d = crc_q; sum_d = sum_q; crch_d = crch_q;
		sl = '0;
		n  = '0;
		case (mode_t'(item.mode))
			MODE_START: begin
				attempt_d = '0; try_d = TRY_C; crc_mode_d = 1'b0; exp_blk_d = 8'd1;
				retrans_d = cfg.max_retrans; deliv_d = '0; wait_d = '0; idx_d = '0;
				large_d = 1'b0; blk_d = '0; inv_d = '0; crc_d = '0; sum_d = '0;
				crch_d = '0; phase_d = PH_HEADER;
				put(sl, n, K_TX, CH_C, '0, ST_COMPLETE);
			end
			MODE_BYTE, MODE_TICK: begin
				logic do_att, do_rej, do_pkt;
				do_att = 1'b0; do_rej = 1'b0; do_pkt = 1'b0;
				if (item.mode == MODE_TICK) begin
					if (phase_q != PH_IDLE) begin
						wait_d = wait_inc;
						if (phase_q == PH_HEADER) do_att = wait_inc >= hdr_lim;
						else if (phase_q == PH_CANWAIT) do_att = wait_inc >= sht_lim;
						else do_rej = wait_inc >= sht_lim;
					end
				end else begin
					case (phase_q)
						PH_HEADER: begin
							if (b == CH_SOH || b == CH_STX) begin
								if (try_q == TRY_C) crc_mode_d = 1'b1;
								try_d = TRY_NONE; large_d = (b == CH_STX);
								idx_d = '0; crc_d = '0; sum_d = '0; crch_d = '0;
								wait_d = '0; phase_d = PH_BODY;
							end else if (b == CH_EOT) begin
								put(sl, n, K_TX, CH_ACK, '0, ST_COMPLETE);
								put(sl, n, K_DONE, 8'd0, '0, ST_COMPLETE);
								phase_d = PH_IDLE;
							end else if (b == CH_CAN) begin
								wait_d = '0; phase_d = PH_CANWAIT;
							end else do_att = 1'b1;
						end
						PH_CANWAIT: begin
							if (b == CH_CAN) begin
								put(sl, n, K_TX, CH_ACK, '0, ST_COMPLETE);
								put(sl, n, K_DONE, 8'd0, '0, ST_CANCEL);
								phase_d = PH_IDLE;
							end else do_att = 1'b1;
						end
						PH_BODY: begin
							idx_d = idx_q + 11'd1;
							if (idx_q == 11'd0) blk_d = b;
							else if (idx_q == 11'd1) inv_d = b;
							else if (idx_q < size + 11'd2) begin
								crc_d = crc_update(crc_q, b);
								sum_d = sum_q + b;
								put(sl, n, K_PAY, b, '0, ST_COMPLETE);
							end else if (crc_mode_q && idx_q == size + 11'd2) crch_d = b;
							else do_pkt = 1'b1;
						end
						default: ;
					endcase
				end
				if (do_att) begin
					attempt_d = att_inc; wait_d = '0;
					if (att_inc < sync_lim) begin
						phase_d = PH_HEADER;
						if (try_q != TRY_NONE)
							put(sl, n, K_TX, (try_q == TRY_C) ? CH_C : CH_NAK, '0,
								ST_COMPLETE);
					end else if (try_q == TRY_C) begin
						try_d = TRY_NAK; attempt_d = '0; phase_d = PH_HEADER;
						put(sl, n, K_TX, CH_NAK, '0, ST_COMPLETE);
					end else begin
						put(sl, n, K_TX, CH_CAN, '0, ST_COMPLETE);
						put(sl, n, K_TX, CH_CAN, '0, ST_COMPLETE);
						put(sl, n, K_TX, CH_CAN, '0, ST_COMPLETE);
						put(sl, n, K_DONE, 8'd0, '0, ST_SYNC);
						phase_d = PH_IDLE;
					end
				end
				if (do_pkt && !(blk_ok && (is_new || is_dup) && chk_ok)) do_rej = 1'b1;
				if (do_rej) begin
					put(sl, n, K_DISCARD, 8'd0, '0, ST_COMPLETE);
					put(sl, n, K_TX, CH_NAK, '0, ST_COMPLETE);
					phase_d = PH_HEADER; attempt_d = '0; wait_d = '0;
				end else if (do_pkt) begin
					logic canc;
					canc = 1'b0;
					if (is_new) begin
						deliv_d = deliv_q + {13'd0, cnt};
						exp_blk_d = exp_blk_q + 8'd1;
						put(sl, n, K_COMMIT, 8'd0, cnt, ST_COMPLETE);
						retrans_d = cfg.max_retrans;
						canc = cfg.max_retrans == 8'd0;
					end else begin
						put(sl, n, K_DISCARD, 8'd0, '0, ST_COMPLETE);
						if (retrans_q <= 8'd1) begin
							retrans_d = '0; canc = 1'b1;
						end else retrans_d = retrans_q - 8'd1;
					end
					if (canc) begin
						put(sl, n, K_TX, CH_CAN, '0, ST_COMPLETE);
						put(sl, n, K_TX, CH_CAN, '0, ST_COMPLETE);
						put(sl, n, K_TX, CH_CAN, '0, ST_COMPLETE);
						put(sl, n, K_DONE, 8'd0, '0, ST_RETRANS);
						phase_d = PH_IDLE;
					end else begin
						put(sl, n, K_TX, CH_ACK, '0, ST_COMPLETE);
						phase_d = PH_HEADER; attempt_d = '0; wait_d = '0;
					end
				end
			end
			default: ;
		endcase
		batch.slot  = sl;
		batch.count = n;
		batch.total = deliv_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; attempt_q <= '0; try_q <= TRY_C; crc_mode_q <= 1'b0;
			exp_blk_q <= 8'd1; retrans_q <= DEF_MAX_RETRANS; deliv_q <= '0;
			wait_q <= '0; idx_q <= '0; large_q <= 1'b0; blk_q <= '0; inv_q <= '0;
			crc_q <= '0; sum_q <= '0; crch_q <= '0;
		end else if (step) begin
			phase_q <= phase_d; attempt_q <= attempt_d; try_q <= try_d;
			crc_mode_q <= crc_mode_d; exp_blk_q <= exp_blk_d; retrans_q <= retrans_d;
			deliv_q <= deliv_d; wait_q <= wait_d; idx_q <= idx_d; large_q <= large_d;
			blk_q <= blk_d; inv_q <= inv_d; crc_q <= crc_d; sum_q <= sum_d;
			crch_q <= crch_d;
		end
	end

endmodule
`default_nettype wire

@@ src/xmr_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmr_outq
// Two-entry batch buffer that serializes each batch onto the result channel.
// ----------------------------------------------------------------------------
module xmr_outq import xmr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire batch_t    din,
	output logic           room,
	output logic           out_valid,
	output out_item_t      dout,
	input  wire logic      out_ready
);

	batch_t [1:0]     buf_q;
	logic   [1:0]     full_q;
	logic             rd_q, wr_q;
	logic [RES_W-1:0] pos_q;
	batch_t           cur;
	logic             pop_item, pop_batch, cur_last;

	assign cur       = buf_q[rd_q];
	assign out_valid = full_q[rd_q];
	assign cur_last  = (pos_q + RES_W'(1)) == cur.count;
	assign pop_item  = out_valid && out_ready;
	assign pop_batch = pop_item && cur_last;
	// room when a slot is free; push of an empty batch is dropped
	assign room      = !full_q[wr_q];

	always_comb begin
		dout.out_kind     = cur.slot[pos_q].kind;
		dout.out_byte     = cur.slot[pos_q].data;
		dout.commit_count = cur.slot[pos_q].count;
		dout.status       = cur.slot[pos_q].status;
		dout.total_length = cur.total;
		dout.last         = cur_last;
	end

	always_ff @(posedge clk) begin
		if (push && din.count != '0) buf_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0; pos_q <= '0;
		end else begin
			if (pop_item) pos_q <= cur_last ? '0 : pos_q + RES_W'(1);
			if (pop_batch) begin
				full_q[rd_q] <= 1'b0;
				rd_q <= ~rd_q;
			end
			if (push && din.count != '0) begin
				full_q[wr_q] <= 1'b1;
				wr_q <= ~wr_q;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/xmodem_receiver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmodem_receiver
// XMODEM receiver (CRC-16 / checksum) driven by start, byte and tick items.
// ----------------------------------------------------------------------------
// An accepted item's results are registered into the batch buffer first.
// Throughput: one item per cycle when each yields at most one result and no
//   stall; an item with several results holds the result port until taken,
//   the two-batch buffer absorbs one batch while the previous drains.
// Reset: arst_n clears protocol state, config to defaults, and the buffer.
module xmodem_receiver import xmr_pkg::*; #(
	parameter logic [23:0] CAPACITY_RST = DEF_CAPACITY
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_wdata
);

	cfg_t   cfg_q;
	batch_t batch;
	logic   step, room;

	// config registers, plain write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{capacity: CAPACITY_RST, header_wait: DEF_HEADER_WAIT,
			           short_wait: DEF_SHORT_WAIT, sync_retries: DEF_SYNC_RETRY,
			           max_retrans: DEF_MAX_RETRANS};
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CAPACITY:    cfg_q.capacity     <= cfg_wdata;
				REG_HEADER_WAIT: cfg_q.header_wait  <= cfg_wdata[15:0];
				REG_SHORT_WAIT:  cfg_q.short_wait   <= cfg_wdata[15:0];
				REG_SYNC_RETRY:  cfg_q.sync_retries <= cfg_wdata[7:0];
				REG_MAX_RETRANS: cfg_q.max_retrans  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// accept whenever a batch slot is free
	assign in_ready = room;
	assign step     = in_valid && in_ready;

	xmr_core u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .item(in_data), .cfg(cfg_q),
		.batch(batch)
	);

	xmr_outq u_outq (
		.clk(clk), .arst_n(arst_n), .push(step), .din(batch), .room(room),
		.out_valid(out_valid), .dout(out_data), .out_ready(out_ready)
	);

endmodule
`default_nettype wire

@@ src/xmr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmr_checker
// Port-level checks for the XMODEM receiver.
// ----------------------------------------------------------------------------
module xmr_checker import xmr_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input item withdrawn before acceptance");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_kind == K_DONE |-> out_data.last)
		else $error("finished not last");

	a_commit_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_kind == K_COMMIT |-> out_data.commit_count <= 11'd1024)
		else $error("commit count too large");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_kind != K_DONE |-> out_data.status == ST_COMPLETE)
		else $error("status on non-finish item");

endmodule

bind xmodem_receiver xmr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM receiver testbench
// Directed table plus randomized sessions, scored against a cycle-free
// behavioral predictor of the receive protocol, with random sender bursts
// and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import xmr_pkg::*;

	localparam int ITEM_BUDGET = 380;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_wdata = '0;

	always #1 clk = ~clk;

	xmodem_receiver DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// ------------------------------------------------------------------
	// Protocol predictor: own copy of registers and receiver state
	// ------------------------------------------------------------------
	logic [23:0] m_cap;
	logic [15:0] m_hwait, m_swait;
	logic [7:0]  m_sync, m_retr;

	phase_t      m_phase;
	logic [7:0]  m_attempts;
	try_t        m_try;
	logic        m_crc_mode;
	logic [7:0]  m_exp_blk;
	logic [7:0]  m_retr_left;
	logic [23:0] m_delivered;
	logic [15:0] m_wait;
	logic [10:0] m_idx;
	logic        m_big;
	logic [7:0]  m_blk, m_blk_inv;
	logic [15:0] m_crc;
	logic [7:0]  m_sum, m_crc_hi;

	out_item_t   expected_q[$];
	int          step_cnt;    // results produced by the current item
	int          errors = 0;

	// crc-16/xmodem, one byte, msb first
	function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
		return r;
	endfunction

	task automatic push_res(kind_t k, logic [7:0] b, logic [10:0] n, status_t s);
		out_item_t r;
		r.out_kind = k;
		r.out_byte = b;
		r.commit_count = n;
		r.status = s;
		r.total_length = m_delivered;
		r.last = 1'b0;
		expected_q.push_back(r);
		step_cnt++;
	endtask

	task automatic tx(logic [7:0] b);
		push_res(K_TX, b, '0, ST_COMPLETE);
	endtask

	task automatic finish_session(status_t s);
		push_res(K_DONE, 8'h00, '0, s);
		m_phase = PH_IDLE;
	endtask

	task automatic cancel_session(status_t s);
		tx(CH_CAN); tx(CH_CAN); tx(CH_CAN);
		finish_session(s);
	endtask

	task automatic end_attempt();
		logic [7:0] lim;
		lim = (m_sync == 0) ? 8'd1 : m_sync;
		m_attempts = m_attempts + 8'd1;
		m_wait = '0;
		if (m_attempts < lim) begin
			m_phase = PH_HEADER;
			if (m_try != TRY_NONE)
				tx(m_try == TRY_C ? CH_C : CH_NAK);
		end else if (m_try == TRY_C) begin
			m_try = TRY_NAK;
			m_attempts = '0;
			m_phase = PH_HEADER;
			tx(CH_NAK);
		end else begin
			cancel_session(ST_SYNC);
		end
	endtask

	task automatic reject_packet();
		push_res(K_DISCARD, 8'h00, '0, ST_COMPLETE);
		tx(CH_NAK);
		m_phase = PH_HEADER;
		m_attempts = '0;
		m_wait = '0;
	endtask

	task automatic close_packet(bit ok);
		int   size, cnt;
		bit   blk_ok, is_new, is_dup;
		size = m_big ? 1024 : 128;
		blk_ok = (m_blk == ~m_blk_inv);
		is_new = (m_blk == m_exp_blk);
		is_dup = (m_blk == m_exp_blk - 8'd1);
		if (!(blk_ok && (is_new || is_dup) && ok)) begin
			reject_packet();
			return;
		end
		if (is_new) begin
			cnt = 0;
			if (m_cap > m_delivered) begin
				cnt = m_cap - m_delivered;
				if (cnt > size) cnt = size;
			end
			m_delivered = m_delivered + cnt[23:0];
			m_exp_blk = m_exp_blk + 8'd1;
			push_res(K_COMMIT, 8'h00, cnt[10:0], ST_COMPLETE);
			m_retr_left = m_retr;
			if (m_retr_left == 0) begin
				cancel_session(ST_RETRANS);
				return;
			end
		end else begin
			push_res(K_DISCARD, 8'h00, '0, ST_COMPLETE);
			if (m_retr_left <= 1) begin
				m_retr_left = '0;
				cancel_session(ST_RETRANS);
				return;
			end
			m_retr_left--;
		end
		tx(CH_ACK);
		m_phase = PH_HEADER;
		m_attempts = '0;
		m_wait = '0;
	endtask

	task automatic body_in(logic [7:0] b);
		int size, i;
		size = m_big ? 1024 : 128;
		i = m_idx;
		m_idx = m_idx + 11'd1;
		if (i == 0) m_blk = b;
		else if (i == 1) m_blk_inv = b;
		else if (i < size + 2) begin
			m_crc = crc16_byte(m_crc, b);
			m_sum = m_sum + b;
			push_res(K_PAY, b, '0, ST_COMPLETE);
		end else if (m_crc_mode) begin
			if (i == size + 2) m_crc_hi = b;
			else close_packet({m_crc_hi, b} == m_crc);
		end else begin
			close_packet(b == m_sum);
		end
	endtask

	task automatic header_in(logic [7:0] b);
		if (b == CH_SOH || b == CH_STX) begin
			if (m_try == TRY_C) m_crc_mode = 1'b1;
			m_try = TRY_NONE;
			m_big = (b == CH_STX);
			m_idx = '0; m_crc = '0; m_sum = '0; m_crc_hi = '0; m_wait = '0;
			m_phase = PH_BODY;
		end else if (b == CH_EOT) begin
			tx(CH_ACK);
			finish_session(ST_COMPLETE);
		end else if (b == CH_CAN) begin
			m_wait = '0;
			m_phase = PH_CANWAIT;
		end else begin
			end_attempt();
		end
	endtask

	function automatic bit tick_out(logic [15:0] lim);
		m_wait = m_wait + 16'd1;
		return m_wait >= ((lim == 0) ? 16'd1 : lim);
	endfunction

	task automatic clear_session();
		m_attempts = '0; m_try = TRY_C; m_crc_mode = 1'b0; m_exp_blk = 8'd1;
		m_retr_left = m_retr; m_delivered = '0; m_wait = '0; m_idx = '0;
		m_big = 1'b0; m_blk = '0; m_blk_inv = '0; m_crc = '0; m_sum = '0;
		m_crc_hi = '0;
	endtask

	task automatic predictor_reset();
		m_cap = DEF_CAPACITY; m_hwait = DEF_HEADER_WAIT; m_swait = DEF_SHORT_WAIT;
		m_sync = DEF_SYNC_RETRY; m_retr = DEF_MAX_RETRANS;
		m_phase = PH_IDLE;
		clear_session();
	endtask

	// work out the results of one accepted item
	task automatic predict_item(in_item_t it);
		step_cnt = 0;
		case (mode_t'(it.mode))
			MODE_START: begin
				clear_session();
				m_phase = PH_HEADER;
				tx(CH_C);
			end
			MODE_BYTE: begin
				case (m_phase)
					PH_HEADER: header_in(it.rx_byte);
					PH_CANWAIT: begin
						if (it.rx_byte == CH_CAN) begin
							tx(CH_ACK);
							finish_session(ST_CANCEL);
						end else end_attempt();
					end
					PH_BODY: body_in(it.rx_byte);
					default: ;
				endcase
			end
			MODE_TICK: begin
				case (m_phase)
					PH_HEADER:  if (tick_out(m_hwait)) end_attempt();
					PH_CANWAIT: if (tick_out(m_swait)) end_attempt();
					PH_BODY:    if (tick_out(m_swait)) reject_packet();
					default: ;
				endcase
			end
			default: ;
		endcase
		if (step_cnt > 0)
			expected_q[$].last = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Result checking; receiver stalls on a pattern of its own
	// ------------------------------------------------------------------
	int stall_mode = 0;   // 0 no stalls, 1 random, 2 heavy
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %p", $realtime, out_data);
					errors++;
				end else begin
					out_item_t e;
					e = expected_q.pop_front();
					if (e !== out_data) begin
						$display("%0t: expected %p actual %p", $realtime, e, out_data);
						errors++;
					end
				end
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sender: bursts with random gaps
	// ------------------------------------------------------------------
	int gap_max = 3;
	int burst_left = 0;
	int sent_n = 0;       // items accepted so far

	// valid stays high across a burst; it drops for a gap and while draining
	task automatic send_item(logic [1:0] md, logic [7:0] b);
		in_item_t it;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		it.mode = md;
		it.rx_byte = b;
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_item(it);
		sent_n++;
	endtask

	task automatic drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (expected_q.size() != 0) begin
			@(posedge clk);
			n++;
			if (n > 20000) break;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CAPACITY:    m_cap = val;
			REG_HEADER_WAIT: m_hwait = val[15:0];
			REG_SHORT_WAIT:  m_swait = val[15:0];
			REG_SYNC_RETRY:  m_sync = val[7:0];
			REG_MAX_RETRANS: m_retr = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// well-formed packet with random content; flaws injected on request
	task automatic send_packet(bit big, logic [7:0] blk, bit bad_blk, bit bad_chk,
			int cut);
		logic [15:0] c;
		logic [7:0]  s, b;
		int size;
		size = big ? 1024 : 128;
		c = '0; s = '0;
		send_item(MODE_BYTE, big ? CH_STX : CH_SOH);
		send_item(MODE_BYTE, blk);
		send_item(MODE_BYTE, bad_blk ? blk : ~blk);
		for (int i = 0; i < size; i++) begin
			if (cut > 0 && i == cut) return;
			b = 8'($urandom_range(0, 255));
			c = crc16_byte(c, b);
			s = s + b;
			send_item(MODE_BYTE, b);
		end
		if (bad_chk) begin c = ~c; s = ~s; end
		if (m_crc_mode) begin
			send_item(MODE_BYTE, c[15:8]);
			send_item(MODE_BYTE, c[7:0]);
		end else send_item(MODE_BYTE, s);
	endtask

	// directed table: mode, byte, expected kind/byte/status of the first result
	typedef struct {
		logic [1:0] md;
		logic [7:0] b;
		bit         chk;
		kind_t      k;
		logic [7:0] ob;
		status_t    st;
	} row_t;

	row_t dir_tab[] = '{
		'{MODE_BYTE,  8'hFF, 0, K_TX, 8'h00, ST_COMPLETE},  // idle: ignored
		'{MODE_TICK,  8'h00, 0, K_TX, 8'h00, ST_COMPLETE},
		'{MODE_NONE,  8'hFF, 0, K_TX, 8'h00, ST_COMPLETE},  // unused mode
		'{MODE_START, 8'h00, 1, K_TX, CH_C,  ST_COMPLETE},
		'{MODE_BYTE,  8'h00, 1, K_TX, CH_C,  ST_COMPLETE},  // other header byte
		'{MODE_BYTE,  CH_CAN, 0, K_TX, 8'h00, ST_COMPLETE},
		'{MODE_BYTE,  8'h55, 1, K_TX, CH_C,  ST_COMPLETE},  // lone CAN
		'{MODE_BYTE,  CH_CAN, 0, K_TX, 8'h00, ST_COMPLETE},
		'{MODE_TICK,  8'h00, 0, K_TX, 8'h00, ST_COMPLETE},
		'{MODE_BYTE,  CH_CAN, 1, K_TX, CH_ACK, ST_COMPLETE}, // double CAN
		'{MODE_BYTE,  CH_CAN, 0, K_TX, 8'h00, ST_COMPLETE},  // idle: ignored
		'{MODE_START, 8'hFF, 1, K_TX, CH_C,  ST_COMPLETE},
		'{MODE_START, 8'h00, 1, K_TX, CH_C,  ST_COMPLETE},  // restart mid-session
		'{MODE_BYTE,  CH_EOT, 1, K_TX, CH_ACK, ST_COMPLETE},
		'{MODE_TICK,  8'hAA, 0, K_TX, 8'h00, ST_COMPLETE}
	};

	initial begin
		int stop;
		predictor_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; typed-in first result checked on top of the predictor
		foreach (dir_tab[r]) begin
			int first;
			send_item(dir_tab[r].md, dir_tab[r].b);
			first = expected_q.size() - step_cnt;
			if (dir_tab[r].chk && (step_cnt == 0 ||
					expected_q[first].out_kind != dir_tab[r].k ||
					expected_q[first].out_byte != dir_tab[r].ob ||
					expected_q[first].status != dir_tab[r].st)) begin
				$display("%0t: table row %0d expected kind %0d byte %h", $realtime, r,
					dir_tab[r].k, dir_tab[r].ob);
				errors++;
			end
		end
		drain();

		// short waits and retries: timeouts, sync fallback, sync cancel
		write_reg(REG_HEADER_WAIT, 24'd0);
		write_reg(REG_SHORT_WAIT, 24'd2);
		write_reg(REG_SYNC_RETRY, 24'd0);
		write_reg(REG_MAX_RETRANS, 24'd0);
		write_reg(REG_CAPACITY, 24'd0);
		send_item(MODE_START, 8'h00);
		send_item(MODE_TICK, 8'h00);     // C attempts out, NAK mode
		send_item(MODE_TICK, 8'h00);     // cancel: sync timeout
		send_item(MODE_START, 8'h00);
		send_packet(0, 8'd1, 0, 0, 0);   // zero retrans limit: cancel
		drain();

		stall_mode = 1;
		gap_max = 0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_CAPACITY, 24'hFFFFFF);
					write_reg(REG_HEADER_WAIT, 24'hFFFF);
					write_reg(REG_SHORT_WAIT, 24'hFFFF);
					write_reg(REG_SYNC_RETRY, 24'd255);
					write_reg(REG_MAX_RETRANS, 24'd255);
				end
				1: begin
					write_reg(REG_CAPACITY, 24'd200);
					write_reg(REG_HEADER_WAIT, 24'd3);
					write_reg(REG_SHORT_WAIT, 24'd40);
					write_reg(REG_SYNC_RETRY, 24'd2);
					write_reg(REG_MAX_RETRANS, 24'd2);
				end
				2: begin gap_max = 4; stall_mode = 2; write_reg(REG_SYNC_RETRY, 24'd1); end
				3: begin stall_mode = 0; write_reg(REG_MAX_RETRANS, 24'd1); end
				4: begin stall_mode = 1; write_reg(REG_CAPACITY, 24'd300); end
				default: begin gap_max = 2; write_reg(REG_SHORT_WAIT, 24'd1); end
			endcase
			// each phase takes an even share of the items still left
			stop = sent_n + (ITEM_BUDGET - sent_n) / (6 - ph);
			send_item(MODE_START, 8'h00);
			while (sent_n < stop) begin
				int pick;
				logic [7:0] blk;
				pick = $urandom_range(0, 19);
				blk = m_exp_blk;
				if (m_phase == PH_IDLE) send_item(MODE_START, 8'h00);
				else if (pick < 9 && sent_n + 131 <= ITEM_BUDGET + 40)
					send_packet(0, ($urandom_range(0, 3) == 0) ? blk - 8'd1 : blk,
						$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, 0);
				else if (pick < 12)
					send_packet(0, blk, 0, 0, $urandom_range(1, 60));
				else if (pick < 15)
					repeat ($urandom_range(1, 8))
						send_item(MODE_TICK, 8'($urandom_range(0, 255)));
				else if (pick < 17)
					send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
				else if (pick == 17) begin
					send_item(MODE_BYTE, CH_CAN);
					send_item(2'($urandom_range(1, 2)), $urandom_range(0, 1) ? CH_CAN :
						8'($urandom_range(0, 255)));
				end else if (pick == 18)
					send_item(MODE_BYTE, CH_EOT);
				else
					send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
			drain();
		end

		if (errors == 0 && expected_q.size() == 0)
			$display("xmodem_receiver: match");
		else
			$display("xmodem_receiver: mismatch");
		$finish;
	end

	initial begin
		#4000000;
		$display("xmodem_receiver: mismatch");
		$finish;
	end

endmodule
